// ===== sv/cubic_root_finder_halley_top_macros.svh =====
// Assertion macros shared by the cubic root finder RTL.
`ifndef CUBIC_ROOT_FINDER_HALLEY_TOP_MACROS_SVH
`define CUBIC_ROOT_FINDER_HALLEY_TOP_MACROS_SVH

// Implication checked on every clk edge outside reset.
`define CRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/crf_pkg.sv =====
// Shared types, constants and helpers for the cubic root finder.
`default_nettype none
package crf_pkg;
    localparam int CRF_NUM_GUESSES = 3;
    localparam int CRF_FRAC_BITS   = 16;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic  start;
        wide_t op_a;
        wide_t op_b;
    } arith_req_t;

    typedef struct packed {
        logic  done;
        logic  ov;
        wide_t value;
    } arith_rsp_t;

    // intermediate magnitude limit, 2^62
    localparam wide_t WLIM     = 64'sh4000_0000_0000_0000;
    localparam wide_t WLIM_NEG = 64'shC000_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_TOLERANCE = 3'd0;
    localparam logic [2:0] CFG_MAX_ITER  = 3'd1;
    localparam logic [2:0] CFG_DUP_DIST  = 3'd2;
    localparam logic [2:0] CFG_GUESS0    = 3'd3;
    localparam logic [2:0] CFG_GUESS1    = 3'd4;
    localparam logic [2:0] CFG_GUESS2    = 3'd5;

    function automatic logic [63:0] mag64(input wide_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction
endpackage
`default_nettype wire

// ===== sv/crf_mul.sv =====
// Shared fixed-point multiplier: four 32x32 partial products, then scale and range check.
`default_nettype none
module crf_mul #(
    parameter int FRAC_BITS = crf_pkg::CRF_FRAC_BITS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  crf_pkg::arith_req_t req,
    output crf_pkg::arith_rsp_t rsp
);
    import crf_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;
    logic         ov_reg;
    wide_t        res_reg;

    logic [31:0]  part_a;
    logic [31:0]  part_b;
    logic [127:0] addend;
    logic [63:0]  scaled;

    assign part_a = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign part_b = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign scaled = {2'b00, acc_reg[FRAC_BITS+61:FRAC_BITS]};

    always_comb
    begin
        case (cnt_reg)
            3'd1:    addend = {64'd0, prod_reg};
            3'd2,
            3'd3:    addend = {32'd0, prod_reg, 32'd0};
            3'd4:    addend = {prod_reg, 64'd0};
            default: addend = 128'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= mag64(req.op_a);
            mb_reg  <= mag64(req.op_b);
            neg_reg <= req.op_a[63] ^ req.op_b[63];
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
                prod_reg <= 64'(part_a) * 64'(part_b);
            acc_reg <= acc_reg + addend;
            if (cnt_reg == 3'd5)
            begin
                ov_reg  <= |acc_reg[127:FRAC_BITS+62];
                res_reg <= neg_reg ? -wide_t'(scaled) : wide_t'(scaled);
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.ov    = ov_reg;
    assign rsp.value = res_reg;
endmodule
`default_nettype wire

// ===== sv/crf_div.sv =====
// Bit-serial restoring divider for the Halley step, one quotient bit a cycle.
`default_nettype none
module crf_div #(
    parameter int FRAC_BITS = crf_pkg::CRF_FRAC_BITS
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  crf_pkg::arith_req_t req,
    output crf_pkg::arith_rsp_t rsp
);
    import crf_pkg::*;

    localparam int DIV_STEPS = 128;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [127:0]     dvd_reg;
    logic [63:0]      rem_reg;
    logic [63:0]      q_reg;
    logic [63:0]      md_reg;
    logic             neg_reg;
    logic             ov_reg;

    logic [64:0] rem2;
    logic [64:0] diff;
    logic        ge;

    assign rem2 = {rem_reg, dvd_reg[127]};
    assign diff = rem2 - {1'b0, md_reg};
    assign ge   = !diff[64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= {64'd0, mag64(req.op_a)} << FRAC_BITS;
            md_reg  <= mag64(req.op_b);
            neg_reg <= req.op_a[63] ^ req.op_b[63];
            rem_reg <= 64'd0;
            q_reg   <= 64'd0;
            ov_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            // quotient already at 2^61 before the shift: step out of range
            if (q_reg[63:61] != 3'd0)
                ov_reg <= 1'b1;
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= ge ? diff[63:0] : rem2[63:0];
            dvd_reg <= {dvd_reg[126:0], 1'b0};
        end
    end

    // signed quotient straight from the shift register, valid with done
    assign rsp.done  = done_reg;
    assign rsp.ov    = ov_reg;
    assign rsp.value = neg_reg ? -wide_t'(q_reg) : wide_t'(q_reg);
endmodule
`default_nettype wire

// ===== sv/cubic_root_finder_halley_top.sv =====
// Top level of the cubic root finder: Halley sequencer, configuration and result stage.
//
// Takes one coefficient word (a, b, c, d of a*x^3 + b*x^2 + c*x + d, signed
// Q16.16) and runs Halley's iteration from up to three configured start
// guesses. Each iteration issues nine multiplies in turn to one shared
// multiplier (four 32x32 partials each) and one divide to a bit-serial
// divider. A guess runs at most max_iterations iterations, after a set-up
// state, and a converged guess then passes a duplicate check. req_stall
// is high from acceptance until the final result word is loaded into the
// output register, so the block works on one coefficient word at a time.
// Results leave in ascending order, one word per root, the final one with
// last set; if no root survives a single word with root_valid low is sent.
// The next coefficient word may be accepted while the final result word
// still waits in the output register. Configuration writes are always
// taken (cfg_ready tied high) and must be made while the block is idle;
// indexes 6 and 7 are ignored.
`default_nettype none
module cubic_root_finder_halley_top #(
    parameter int NUM_GUESSES = crf_pkg::CRF_NUM_GUESSES,
    parameter int FRAC_BITS   = crf_pkg::CRF_FRAC_BITS
) (
    input  wire            clk,
    input  wire            rst_n,
    // coefficient channel
    input  wire            req_valid,
    output logic           req_stall,
    input  crf_pkg::word_t coef_a,
    input  crf_pkg::word_t coef_b,
    input  crf_pkg::word_t coef_c,
    input  crf_pkg::word_t coef_d,
    // result channel
    output logic           rsp_valid,
    input  wire            rsp_stall,
    output crf_pkg::word_t root,
    output logic [1:0]     root_index,
    output logic [1:0]     root_count,
    output logic           root_valid,
    output logic           last,
    // configuration write channel
    input  wire            cfg_valid,
    output logic           cfg_ready,
    input  wire [2:0]      cfg_index,
    input  wire [31:0]     cfg_data
);
    import crf_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_GUESS = 4'd1;
    localparam logic [3:0] ST_MISS  = 4'd2;
    localparam logic [3:0] ST_MWAIT = 4'd3;
    localparam logic [3:0] ST_CHECK = 4'd4;
    localparam logic [3:0] ST_DWAIT = 4'd5;
    localparam logic [3:0] ST_DUP   = 4'd6;
    localparam logic [3:0] ST_SORT  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    // micro-steps of one iteration, one multiply each
    localparam logic [3:0] MS_FX0 = 4'd0;  // a*x + b
    localparam logic [3:0] MS_FX1 = 4'd1;  // fx*x + c
    localparam logic [3:0] MS_FX2 = 4'd2;  // fx*x + d
    localparam logic [3:0] MS_FP0 = 4'd3;  // 3a*x + 2b
    localparam logic [3:0] MS_FP1 = 4'd4;  // fp*x + c
    localparam logic [3:0] MS_FPP = 4'd5;  // 6a*x + 2b
    localparam logic [3:0] MS_DN0 = 4'd6;  // 2*fp*fp
    localparam logic [3:0] MS_DN1 = 4'd7;  // den - fx*fpp
    localparam logic [3:0] MS_NUM = 4'd8;  // 2*fx*fp

    logic [3:0]  state_reg, state_next;
    word_t       ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next, cd_reg, cd_next;
    logic [1:0]  g_reg, g_next;
    word_t       x_reg, x_next;
    logic [15:0] it_reg, it_next;
    logic [3:0]  step_reg, step_next;
    wide_t       fx_reg, fx_next, fp_reg, fp_next, fpp_reg, fpp_next;
    wide_t       den_reg, den_next, num_reg, num_next;
    word_t       cand_reg, cand_next;
    logic [1:0]  n_reg, n_next;
    word_t       r_reg [3];
    word_t       r_next [3];
    logic [1:0]  sort_reg, sort_next;
    logic [1:0]  e_reg, e_next;

    logic        rsp_valid_reg, rsp_valid_next;
    word_t       root_reg, root_next;
    logic [1:0]  ridx_reg, ridx_next, rcnt_reg, rcnt_next;
    logic        rval_reg, rval_next, last_reg, last_next;

    logic [15:0] tol_reg, maxit_reg, dupd_reg;
    word_t       gs_reg [3];

    arith_req_t  mul_req, div_req;
    arith_rsp_t  mul_rsp, div_rsp;

    wide_t       a64, b64, c64, d64, a3, a6, b2;
    wide_t       post_v;
    logic        post_ov;
    wide_t       xn;
    logic        xn_fit;
    logic [63:0] q_mag;
    logic [2:0]  near;
    word_t       guess_sel;

    crf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    crf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign a64 = wide_t'(ca_reg);
    assign b64 = wide_t'(cb_reg);
    assign c64 = wide_t'(cc_reg);
    assign d64 = wide_t'(cd_reg);
    assign a3  = a64 + (a64 <<< 1);
    assign a6  = a3 <<< 1;
    assign b2  = b64 <<< 1;

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_req.start = (state_reg == ST_MISS);
        case (step_reg)
            MS_FX0:  begin mul_req.op_a = a64; mul_req.op_b = wide_t'(x_reg); end
            MS_FX1,
            MS_FX2:  begin mul_req.op_a = fx_reg; mul_req.op_b = wide_t'(x_reg); end
            MS_FP0:  begin mul_req.op_a = a3; mul_req.op_b = wide_t'(x_reg); end
            MS_FP1:  begin mul_req.op_a = fp_reg; mul_req.op_b = wide_t'(x_reg); end
            MS_FPP:  begin mul_req.op_a = a6; mul_req.op_b = wide_t'(x_reg); end
            MS_DN0:  begin mul_req.op_a = fp_reg; mul_req.op_b = fp_reg; end
            MS_DN1:  begin mul_req.op_a = fx_reg; mul_req.op_b = fpp_reg; end
            default: begin mul_req.op_a = fx_reg; mul_req.op_b = fp_reg; end
        endcase
    end

    assign div_req.start = (state_reg == ST_CHECK) && (den_reg != '0);
    assign div_req.op_a  = num_reg;
    assign div_req.op_b  = den_reg;

    // add, subtract or double after each multiply, then the 2^62 bound
    always_comb
    begin
        case (step_reg)
            MS_FX0,
            MS_FP0:  post_v = mul_rsp.value + ((step_reg == MS_FX0) ? b64 : b2);
            MS_FX1,
            MS_FP1:  post_v = mul_rsp.value + c64;
            MS_FX2:  post_v = mul_rsp.value + d64;
            MS_FPP:  post_v = mul_rsp.value + b2;
            MS_DN1:  post_v = den_reg - mul_rsp.value;
            default: post_v = mul_rsp.value <<< 1;
        endcase
        post_ov = (post_v >= WLIM) || (post_v <= WLIM_NEG);
    end

    assign xn     = wide_t'(x_reg) - div_rsp.value;
    assign xn_fit = (xn[63:31] == {33{1'b0}}) || (xn[63:31] == {33{1'b1}});
    assign q_mag  = mag64(div_rsp.value);

    // distance of the candidate to every kept root, in parallel
    always_comb
    begin
        logic signed [32:0] dd;
        logic [32:0]        dm;
        for (int k = 0; k < 3; k++)
        begin
            dd = {cand_reg[31], cand_reg} - {r_reg[k][31], r_reg[k]};
            dm = dd[32] ? 33'(-dd) : 33'(dd);
            near[k] = (2'(k) < n_reg) && (dm < {17'd0, dupd_reg});
        end
    end

    always_comb
    begin
        case (g_reg)
            2'd0:    guess_sel = gs_reg[0];
            2'd1:    guess_sel = gs_reg[1];
            default: guess_sel = gs_reg[2];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ca_next = ca_reg; cb_next = cb_reg; cc_next = cc_reg; cd_next = cd_reg;
        g_next = g_reg;
        x_next = x_reg;
        it_next = it_reg;
        step_next = step_reg;
        fx_next = fx_reg; fp_next = fp_reg; fpp_next = fpp_reg;
        den_next = den_reg; num_next = num_reg;
        cand_next = cand_reg;
        n_next = n_reg;
        for (int k = 0; k < 3; k++)
            r_next[k] = r_reg[k];
        sort_next = sort_reg;
        e_next = e_reg;
        rsp_valid_next = rsp_valid_reg;
        root_next = root_reg;
        ridx_next = ridx_reg; rcnt_next = rcnt_reg;
        rval_next = rval_reg; last_next = last_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ca_next = coef_a; cb_next = coef_b;
                    cc_next = coef_c; cd_next = coef_d;
                    g_next = 2'd0;
                    n_next = 2'd0;
                    state_next = ST_GUESS;
                end
            end
            ST_GUESS:
            begin
                if (g_reg >= 2'(NUM_GUESSES))
                begin
                    sort_next = 2'd0;
                    state_next = ST_SORT;
                end
                else
                begin
                    x_next = guess_sel;
                    it_next = 16'd0;
                    step_next = MS_FX0;
                    if (maxit_reg == 16'd0)
                        g_next = g_reg + 2'd1;
                    else
                        state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                state_next = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (mul_rsp.ov || post_ov)
                    begin
                        g_next = g_reg + 2'd1;
                        state_next = ST_GUESS;
                    end
                    else
                    begin
                        case (step_reg)
                            MS_FX0, MS_FX1, MS_FX2: fx_next = post_v;
                            MS_FP0, MS_FP1:         fp_next = post_v;
                            MS_FPP:                 fpp_next = post_v;
                            MS_DN0, MS_DN1:         den_next = post_v;
                            default:                num_next = post_v;
                        endcase
                        if (step_reg == MS_NUM)
                            state_next = ST_CHECK;
                        else
                        begin
                            step_next = step_reg + 4'd1;
                            state_next = ST_MISS;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (den_reg == '0)
                begin
                    g_next = g_reg + 2'd1;
                    state_next = ST_GUESS;
                end
                else
                    state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.ov || !xn_fit)
                    begin
                        g_next = g_reg + 2'd1;
                        state_next = ST_GUESS;
                    end
                    else if (q_mag < {48'd0, tol_reg})
                    begin
                        cand_next = xn[31:0];
                        state_next = ST_DUP;
                    end
                    else
                    begin
                        x_next = xn[31:0];
                        if (it_reg + 16'd1 == maxit_reg)
                        begin
                            g_next = g_reg + 2'd1;
                            state_next = ST_GUESS;
                        end
                        else
                        begin
                            it_next = it_reg + 16'd1;
                            step_next = MS_FX0;
                            state_next = ST_MISS;
                        end
                    end
                end
            end
            ST_DUP:
            begin
                if (near == 3'd0 && n_reg != 2'd3)
                begin
                    case (n_reg)
                        2'd0:    r_next[0] = cand_reg;
                        2'd1:    r_next[1] = cand_reg;
                        default: r_next[2] = cand_reg;
                    endcase
                    n_next = n_reg + 2'd1;
                end
                g_next = g_reg + 2'd1;
                state_next = ST_GUESS;
            end
            ST_SORT:
            begin
                // three compare-exchange passes: (0,1), (1,2), (0,1)
                case (sort_reg)
                    2'd1:
                    begin
                        if (n_reg == 2'd3 && r_reg[1] > r_reg[2])
                        begin
                            r_next[1] = r_reg[2];
                            r_next[2] = r_reg[1];
                        end
                    end
                    default:
                    begin
                        if (n_reg >= 2'd2 && r_reg[0] > r_reg[1])
                        begin
                            r_next[0] = r_reg[1];
                            r_next[1] = r_reg[0];
                        end
                    end
                endcase
                sort_next = sort_reg + 2'd1;
                if (sort_reg == 2'd2)
                begin
                    e_next = 2'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    if (n_reg == 2'd0)
                    begin
                        root_next = '0;
                        ridx_next = 2'd0;
                        rcnt_next = 2'd0;
                        rval_next = 1'b0;
                        last_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        root_next = r_reg[0];
                        ridx_next = e_reg;
                        rcnt_next = n_reg;
                        rval_next = 1'b1;
                        last_next = (e_reg == n_reg - 2'd1);
                        r_next[0] = r_reg[1];
                        r_next[1] = r_reg[2];
                        e_next = e_reg + 2'd1;
                        if (e_reg == n_reg - 2'd1)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            g_reg         <= 2'd0;
            it_reg        <= 16'd0;
            step_reg      <= MS_FX0;
            n_reg         <= 2'd0;
            sort_reg      <= 2'd0;
            e_reg         <= 2'd0;
            tol_reg       <= 16'd7;
            maxit_reg     <= 16'd1000;
            dupd_reg      <= 16'd66;
            gs_reg[0]     <= -32'sd6553600;
            gs_reg[1]     <= 32'sd0;
            gs_reg[2]     <= 32'sd6553600;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            g_reg         <= g_next;
            it_reg        <= it_next;
            step_reg      <= step_next;
            n_reg         <= n_next;
            sort_reg      <= sort_next;
            e_reg         <= e_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TOLERANCE: tol_reg   <= cfg_data[15:0];
                    CFG_MAX_ITER:  maxit_reg <= cfg_data[15:0];
                    CFG_DUP_DIST:  dupd_reg  <= cfg_data[15:0];
                    CFG_GUESS0:    gs_reg[0] <= cfg_data;
                    CFG_GUESS1:    gs_reg[1] <= cfg_data;
                    CFG_GUESS2:    gs_reg[2] <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge clk)
    begin
        ca_reg   <= ca_next;
        cb_reg   <= cb_next;
        cc_reg   <= cc_next;
        cd_reg   <= cd_next;
        x_reg    <= x_next;
        fx_reg   <= fx_next;
        fp_reg   <= fp_next;
        fpp_reg  <= fpp_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        cand_reg <= cand_next;
        for (int k = 0; k < 3; k++)
            r_reg[k] <= r_next[k];
        root_reg <= root_next;
        ridx_reg <= ridx_next;
        rcnt_reg <= rcnt_next;
        rval_reg <= rval_next;
        last_reg <= last_next;
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign root       = root_reg;
    assign root_index = ridx_reg;
    assign root_count = rcnt_reg;
    assign root_valid = rval_reg;
    assign last       = last_reg;

`include "cubic_root_finder_halley_top_macros.svh"

    `CRF_ASSERT_IMP(a_noroot_word, rsp_valid && !root_valid, last && root_count == 2'd0, "empty result word must be the final one with count zero")
    `CRF_ASSERT_IMP(a_last_index, rsp_valid && root_valid && last, root_index + 2'd1 == root_count, "final root word index does not match count")
    `CRF_ASSERT_IMP(a_sorted, state_reg == ST_EMIT && e_reg == 2'd0 && n_reg >= 2'd2, r_reg[0] <= r_reg[1], "roots not ascending at start of emission")
    `CRF_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_reg == ST_GUESS && g_reg == 2'd0 && n_reg == 2'd0, "accepted word did not start the first guess")
endmodule
`default_nettype wire

// ===== tb/cubic_root_finder_halley_top_test.sv =====
// Self-checking testbench for the Halley cubic root finder, with its own fixed-point root predictor.
`default_nettype none
module cubic_root_finder_halley_top_test;
    import crf_pkg::*;

    // One result word as the block should send it.
    typedef struct {
        word_t      root;
        logic [1:0] index;
        logic [1:0] count;
        logic       valid;
        logic       last;
    } root_word_t;

    // Upper bound on the cycles of one Halley iteration in the block.
    // The quiet limit allows every guess to run to the current iteration
    // limit, four times over.
    localparam int ITER_CYCLES = 210;
    // Settling time before a register write, and at the end.
    localparam int SETTLE = 40;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    word_t      coef_a, coef_b, coef_c, coef_d;
    logic       rsp_valid;
    logic       rsp_stall;
    word_t      root;
    logic [1:0] root_index;
    logic [1:0] root_count;
    logic       root_valid;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    cubic_root_finder_halley_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .coef_d     (coef_d),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .root       (root),
        .root_index (root_index),
        .root_count (root_count),
        .root_valid (root_valid),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Mirror of the configuration registers, kept in step with every write.
    longint     tol_q;
    longint     iter_limit;
    longint     dup_dist;
    longint     start_guess [3];

    root_word_t pending_roots [$];
    int         errors;
    int         gap_pct;      // chance of the sender going quiet after a word
    int         stall_pct;    // chance of the receiver stalling in a cycle

    // Clock, period 12.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Fixed-point arithmetic of the root finder, bit exact.
    // ---------------------------------------------------------------------

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // Anything at or beyond 2^62 units in magnitude kills the guess.
    function automatic longint clip_check(input longint v, inout bit ov);
        if (v >= WLIM || v <= WLIM_NEG)
        begin
            ov = 1'b1;
            return 0;
        end
        return v;
    endfunction

    // Exact product, shifted down by the fraction width, truncated to zero.
    function automatic longint q_mul(input longint a, input longint b, inout bit ov);
        logic [127:0] p;
        longint       r;
        p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        p = p >> CRF_FRAC_BITS;
        if (p >= 128'h4000_0000_0000_0000)
        begin
            ov = 1'b1;
            return 0;
        end
        r = longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    // Scaled quotient, truncated to zero; d is never zero here.
    function automatic longint q_div(input longint n, input longint d, inout bit ov);
        logic [127:0] q;
        longint       r;
        q = ({64'd0, abs64(n)} << CRF_FRAC_BITS) / {64'd0, abs64(d)};
        if (q >= 128'h4000_0000_0000_0000)
        begin
            ov = 1'b1;
            return 0;
        end
        r = longint'(q[63:0]);
        return ((n < 0) != (d < 0)) ? -r : r;
    endfunction

    // Halley's iteration from one start; returns 1 with the root on success.
    function automatic bit halley_converge(input longint k [4], input longint x0,
                                           output longint found);
        longint x, fx, fp, fpp, den, num, q, xn;
        bit     ov;
        x     = x0;
        found = 0;
        for (longint it = 0; it < iter_limit; it++)
        begin
            ov  = 1'b0;
            fx  = clip_check(q_mul(k[0], x, ov) + k[1], ov);
            fx  = clip_check(q_mul(fx, x, ov) + k[2], ov);
            fx  = clip_check(q_mul(fx, x, ov) + k[3], ov);
            fp  = clip_check(q_mul(3 * k[0], x, ov) + 2 * k[1], ov);
            fp  = clip_check(q_mul(fp, x, ov) + k[2], ov);
            fpp = clip_check(q_mul(6 * k[0], x, ov) + 2 * k[1], ov);
            den = clip_check(2 * q_mul(fp, fp, ov), ov);
            den = clip_check(den - q_mul(fx, fpp, ov), ov);
            num = clip_check(2 * q_mul(fx, fp, ov), ov);
            if (ov || den == 0)
                return 1'b0;
            q = q_div(num, den, ov);
            if (ov)
                return 1'b0;
            xn = x - q;
            if (xn > 64'sd2147483647 || xn < -64'sd2147483648)
                return 1'b0;
            if (abs64(q) < tol_q)
            begin
                found = xn;
                return 1'b1;
            end
            x = xn;
        end
        return 1'b0;
    endfunction

    // Works out the result words for one coefficient word and queues them.
    task automatic predict_roots(input word_t a, input word_t b, input word_t c, input word_t d);
        longint     k [4];
        longint     kept [3];
        longint     r, t;
        int         n;
        bit         fresh;
        root_word_t w;
        k = '{longint'(a), longint'(b), longint'(c), longint'(d)};
        n = 0;
        for (int g = 0; g < CRF_NUM_GUESSES; g++)
        begin
            if (halley_converge(k, start_guess[g], r))
            begin
                fresh = 1'b1;
                for (int j = 0; j < n; j++)
                    if (abs64(r - kept[j]) < dup_dist)
                        fresh = 1'b0;
                if (fresh && n < 3)
                begin
                    kept[n] = r;
                    n++;
                end
            end
        end
        for (int i = 0; i + 1 < n; i++)
            for (int j = 0; j + 1 < n - i; j++)
                if (kept[j] > kept[j + 1])
                begin
                    t           = kept[j];
                    kept[j]     = kept[j + 1];
                    kept[j + 1] = t;
                end
        if (n == 0)
        begin
            w = '{root: '0, index: 2'd0, count: 2'd0, valid: 1'b0, last: 1'b1};
            pending_roots.push_back(w);
        end
        for (int i = 0; i < n; i++)
        begin
            w.root  = word_t'(kept[i]);
            w.index = 2'(i);
            w.count = 2'(n);
            w.valid = 1'b1;
            w.last  = (i == n - 1);
            pending_roots.push_back(w);
        end
    endtask

    // ---------------------------------------------------------------------
    // Checking.
    // ---------------------------------------------------------------------

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Receiver: random stall, and every accepted word checked against the
    // oldest outstanding prediction.
    always @(posedge clk or negedge rst_n)
    begin
        root_word_t w;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_roots.size() == 0)
                    report("unexpected result word, root", root, 0);
                else
                begin
                    w = pending_roots.pop_front();
                    if (root !== w.root)        report("root", root, w.root);
                    if (root_index !== w.index) report("root_index", root_index, w.index);
                    if (root_count !== w.count) report("root_count", root_count, w.count);
                    if (root_valid !== w.valid) report("root_valid", root_valid, w.valid);
                    if (last !== w.last)        report("last", last, w.last);
                end
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hang detector: too long with no word moving on any channel.
    longint quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= 4 * (CRF_NUM_GUESSES * iter_limit * ITER_CYCLES + 1000))
        begin
            $display("cubic_root_finder_halley_top_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // Driving.
    // ---------------------------------------------------------------------

    // Sends one coefficient word; the prediction is made as it is taken.
    task automatic send_coefs(input word_t a, input word_t b, input word_t c, input word_t d);
        req_valid <= 1'b1;
        coef_a    <= a;
        coef_b    <= b;
        coef_c    <= c;
        coef_d    <= d;
        do
            @(posedge clk);
        while (req_stall);
        predict_roots(a, b, c, d);
        // valid stays high unless a gap is drawn, so it is never dropped and
        // raised in the same step
        if ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Lets everything drain so that a register write finds the block idle.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One write, then a wait with valid low so that valid is never dropped and
    // raised in the same step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TOLERANCE: tol_q          = longint'(value[15:0]);
            CFG_MAX_ITER:  iter_limit     = longint'(value[15:0]);
            CFG_DUP_DIST:  dup_dist       = longint'(value[15:0]);
            CFG_GUESS0:    start_guess[0] = longint'(signed'(value));
            CFG_GUESS1:    start_guess[1] = longint'(signed'(value));
            CFG_GUESS2:    start_guess[2] = longint'(signed'(value));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input int tol, input int iters, input int dup,
                             input int g0, input int g1, input int g2);
        write_reg(CFG_TOLERANCE, 32'(tol));
        write_reg(CFG_MAX_ITER,  32'(iters));
        write_reg(CFG_DUP_DIST,  32'(dup));
        write_reg(CFG_GUESS0,    32'(g0));
        write_reg(CFG_GUESS1,    32'(g1));
        write_reg(CFG_GUESS2,    32'(g2));
    endtask

    // Cubic k*(x-r1)(x-r2)(x-r3) with whole-number roots, plus a few low
    // bits of noise on the constant so the roots land off the grid.
    task automatic send_cubic(input int k, input int r1, input int r2, input int r3,
                              input int fuzz);
        send_coefs(word_t'(k * 65536),
                   word_t'(-k * (r1 + r2 + r3) * 65536),
                   word_t'(k * (r1 * r2 + r1 * r3 + r2 * r3) * 65536),
                   word_t'(-k * r1 * r2 * r3 * 65536 + fuzz));
    endtask

    // ---------------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------------

    // Out of reset: only cubics that converge quickly, since the limit is
    // still 1000 iterations per guess.
    task automatic test_reset_values();
        send_cubic(1, -3, 1, 4, 0);
        send_cubic(2, -50, 0, 60, 0);
        send_cubic(-1, 7, 7, -2, 0);
    endtask

    // Degenerate and failing cases, with a short iteration limit.
    task automatic test_special_cases();
        wait_idle();
        write_all(7, 200, 66, -6553600, 0, 6553600);
        // all zero: the denominator is zero from the start
        send_coefs('0, '0, '0, '0);
        // triple root at one: all three guesses meet, two are dropped
        send_cubic(1, 1, 1, 1, 0);
        // straight line whose root lies outside the word
        send_coefs('0, '0, word_t'(32'h0001_0000), word_t'(32'h8000_0000));
        // coefficient extremes: products overflow
        send_coefs(word_t'(32'h7fff_ffff), word_t'(32'h8000_0000),
                   word_t'(32'h7fff_ffff), word_t'(32'h8000_0000));
        send_coefs(word_t'(32'h8000_0000), word_t'(32'h7fff_ffff),
                   word_t'(32'h8000_0000), word_t'(32'h7fff_ffff));
        send_coefs(word_t'(32'hffff_ffff), '0, '0, word_t'(32'h0000_0001));
        // quadratic with no real root
        send_coefs('0, word_t'(32'h0001_0000), '0, word_t'(32'h0001_0000));
        // one pass allowed: almost every guess gives up
        wait_idle();
        write_reg(CFG_MAX_ITER, 32'd1);
        send_cubic(1, -3, 1, 4, 0);
        send_cubic(1, 0, 0, 0, 0);
    endtask

    // Register extremes.
    task automatic test_register_extremes();
        wait_idle();
        // no duplicate filter, tight tolerance, guesses at the word limits
        write_all(1, 24, 0, 32'h8000_0000, 0, 32'h7fff_ffff);
        send_cubic(1, -3, 1, 4, 0);
        send_cubic(1, 2, 2, 2, 0);
        send_coefs('0, '0, word_t'(32'h0001_0000), word_t'(32'h0000_8000));
        wait_idle();
        // coarsest tolerance, widest duplicate window
        write_all(65535, 65535, 65535, -655360, 65536, 655360);
        send_cubic(1, -5, 0, 5, 0);
        send_cubic(3, -1, 0, 1, 17);
        send_cubic(1, -9, 2, 9, 3);
    endtask

    // Random part: mostly cubics built from real roots, the rest raw words.
    task automatic test_random_cubics(input int count);
        int r1, r2, r3, k;
        for (int i = 0; i < count; i++)
        begin
            // idling pattern changes by thirds; registers with it
            if (i % (count / 3) == 0)
            begin
                wait_idle();
                case (i / (count / 3))
                    0:       begin gap_pct = 22; stall_pct = 50; end
                    1:       begin gap_pct = 50; stall_pct = 22; end
                    default: begin gap_pct = 0;  stall_pct = 0;  end
                endcase
                write_all($urandom_range(1, 300), $urandom_range(4, 20),
                          $urandom_range(0, 4000),
                          -$urandom_range(20, 40) * 65536 - $urandom_range(0, 65535),
                          $urandom_range(0, 131071) - 65536,
                          $urandom_range(20, 40) * 65536 + $urandom_range(0, 65535));
            end
            if ($urandom_range(99) < 70)
            begin
                r1 = $urandom_range(40) - 20;
                r2 = $urandom_range(40) - 20;
                r3 = $urandom_range(40) - 20;
                k  = $urandom_range(1, 3);
                if ($urandom_range(1))
                    k = -k;
                send_cubic(k, r1, r2, r3, $urandom_range(0, 255));
            end
            else if ($urandom_range(1))
                send_coefs(word_t'($urandom), word_t'($urandom),
                           word_t'($urandom), word_t'($urandom));
            else
                // small raw coefficients, well inside the range
                send_coefs(word_t'($urandom_range(0, 524287) - 262144),
                           word_t'($urandom_range(0, 524287) - 262144),
                           word_t'($urandom_range(0, 524287) - 262144),
                           word_t'($urandom_range(0, 524287) - 262144));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        coef_a     = '0;
        coef_b     = '0;
        coef_c     = '0;
        coef_d     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        errors     = 0;
        gap_pct    = 0;
        stall_pct  = 0;
        // reset values of the registers
        tol_q          = 7;
        iter_limit     = 1000;
        dup_dist       = 66;
        start_guess[0] = -6553600;
        start_guess[1] = 0;
        start_guess[2] = 6553600;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_special_cases();
        test_register_extremes();
        test_random_cubics(150);

        wait_idle();
        if (errors == 0)
            $display("cubic_root_finder_halley_top_test: done, clean");
        else
            $display("cubic_root_finder_halley_top_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/crf_pkg.sv
sv/crf_mul.sv
sv/crf_div.sv
sv/cubic_root_finder_halley_top.sv
tb/cubic_root_finder_halley_top_test.sv
